### hw/rtl/alws_pkg.sv
// ----------------------------------------------------------------------------
// alws_pkg: shared types and constants of the array list
// Operation and status codes, list sizing, and the command, result and
// cell control words.
// ----------------------------------------------------------------------------
`default_nettype none

package alws_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int HIT_GRP  = 16;
  localparam int NGRP     = (CAPACITY + HIT_GRP - 1) / HIT_GRP;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_PREPEND    = 3'd1,
    OP_DROP_LAST  = 3'd2,
    OP_DROP_FIRST = 3'd3,
    OP_SEARCH     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
    logic [4:0] count;
  } res_word_t;

  // common controls seen by every cell
  typedef struct packed {
    logic        shr;   // move toward the tail
    logic        shl;   // move toward the head
    logic        cmp;   // compare against key
    logic [31:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/alws_cell.sv
// ----------------------------------------------------------------------------
// alws_cell: one list slot
// Holds one entry, loads from either neighbor or the key, and registers
// a match flag for searches.
// ----------------------------------------------------------------------------
`default_nettype none

module alws_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire alws_pkg::cell_ctl_t ctl_i,
  input  wire logic               wr_i,     // load key here
  input  wire logic               valid_i,  // slot below fill
  input  wire logic [31:0]        left_i,   // entry of slot i-1
  input  wire logic [31:0]        right_i,  // entry of slot i+1
  output logic [31:0]             entry_o,
  output logic                    hit_o
);
  import alws_pkg::*;

  logic [31:0] entry_q, entry_d;
  logic        hit_q, hit_d;

  always_comb begin
    entry_d = entry_q;
    if (wr_i) begin
      entry_d = ctl_i.key;
    end else if (ctl_i.shr) begin
      entry_d = left_i;
    end else if (ctl_i.shl) begin
      entry_d = right_i;
    end
    hit_d = ctl_i.cmp && valid_i && (entry_q == ctl_i.key);
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule

`default_nettype wire

### hw/rtl/alws_hit_tree.sv
// ----------------------------------------------------------------------------
// alws_hit_tree: registered OR of the cell match flags
// Groups of HIT_GRP flags are ORed into registers; the group registers
// are ORed on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module alws_hit_tree (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [alws_pkg::CAPACITY-1:0] hit_i,
  output logic                               any_o
);
  import alws_pkg::*;

  logic [NGRP-1:0][HIT_GRP-1:0] bits;
  logic [NGRP-1:0]              grp_q, grp_d;

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar b = 0; b < HIT_GRP; b++) begin : g_bit
      if (g * HIT_GRP + b < CAPACITY) begin : g_used
        assign bits[g][b] = hit_i[g * HIT_GRP + b];
      end else begin : g_pad
        assign bits[g][b] = 1'b0;
      end
    end
    assign grp_d[g] = |bits[g];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else begin
      grp_q <= grp_d;
    end
  end

  assign any_o = |grp_q;

endmodule

`default_nettype wire

### hw/rtl/array_list_with_search.sv
// ----------------------------------------------------------------------------
// array_list_with_search: bounded ordered list with front/back ops and search
// A row of CAPACITY cells holds the list; all cells shift or compare
// together, so no operation waits on another and the row never stalls.
// ----------------------------------------------------------------------------
//
//  channel   ports                 word          handshake
//  -------   -------------------   -----------   ---------------------------
//  command   start_i, cmd_i        cmd_word_t    taken when start_i & !busy_o
//  result    done_o, res_o         res_word_t    one-cycle strobe, no stall
//
//  - One command per cycle; busy_o stays low, the row never stalls.
//  - Each result is registered behind its command: first in the cell
//    shift/compare, then in the registered OR of the match flags.
//  - Results leave in command order; the receiver cannot hold them off.
//  - Reset clears the fill count and pipeline valids; entries are not
//    cleared, only slots below the fill count are ever compared.
//
`default_nettype none

module array_list_with_search (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire alws_pkg::cmd_word_t  cmd_i,
  output logic                      busy_o,
  output logic                      done_o,
  output alws_pkg::res_word_t       res_o
);
  import alws_pkg::*;

  // fill count and command decode
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             accept;
  logic             is_full, is_empty;
  logic [1:0]       status_d;
  logic             do_append, do_prepend, do_drop_first;
  cell_ctl_t        ctl;

  // result pipeline: stage 1 waits for the hit tree, stage 2 drives ports
  logic             s1_vld_q, s2_vld_q;
  logic [1:0]       s1_status_q, s2_status_q;
  logic [CNT_W-1:0] s1_count_q, s2_count_q;
  logic [CNT_W+4:0] cnt_ext;

  logic [31:0]         ent [CAPACITY];
  logic [CAPACITY-1:0] hit;
  logic                any_hit;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_full  = (fill_q == CNT_W'(CAPACITY));
  assign is_empty = (fill_q == '0);

  always_comb begin
    fill_d        = fill_q;
    status_d      = ST_DONE;
    do_append     = 1'b0;
    do_prepend    = 1'b0;
    do_drop_first = 1'b0;
    ctl.cmp       = 1'b0;
    ctl.key       = cmd_i.value;
    if (accept) begin
      case (cmd_i.op)
        OP_APPEND, OP_PREPEND: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            fill_d        = fill_q + 1'b1;
            do_append     = (cmd_i.op == OP_APPEND);
            do_prepend    = (cmd_i.op == OP_PREPEND);
          end
        end
        OP_DROP_LAST, OP_DROP_FIRST: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            fill_d        = fill_q - 1'b1;
            do_drop_first = (cmd_i.op == OP_DROP_FIRST);
          end
        end
        OP_SEARCH: begin
          ctl.cmp = 1'b1;
        end
        default: begin
          // unused codes leave the list alone
        end
      endcase
    end
    ctl.shr = do_prepend;
    ctl.shl = do_drop_first;
  end

  // row of cells; head is slot 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic        wr;
    logic        vld;
    logic [31:0] left, right;

    assign vld = (CNT_W'(i) < fill_q);
    if (i == 0) begin : g_head
      assign wr   = do_prepend || (do_append && is_empty);
      assign left = cmd_i.value;
    end else begin : g_body
      assign wr   = do_append && (fill_q == CNT_W'(i));
      assign left = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = ent[i];
    end else begin : g_inner
      assign right = ent[i+1];
    end

    alws_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .wr_i    (wr),
      .valid_i (vld),
      .left_i  (left),
      .right_i (right),
      .entry_o (ent[i]),
      .hit_o   (hit[i])
    );
  end

  alws_hit_tree u_hit_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hit_i  (hit),
    .any_o  (any_hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    s1_status_q <= status_d;
    s1_count_q  <= fill_d;
    s2_status_q <= s1_status_q;
    s2_count_q  <= s1_count_q;
  end

  // count port is the low five bits of the fill
  assign cnt_ext      = {5'b0, s2_count_q};
  assign done_o       = s2_vld_q;
  assign res_o.found  = any_hit;
  assign res_o.status = s2_status_q;
  assign res_o.count  = cnt_ext[4:0];

  // fill never passes the capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // every accepted command yields a strobe from the result pipeline
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("missing result strobe");

  // a match is only reported for a completed operation
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.found) |-> (res_o.status == ST_DONE))
    else $error("found with error status");

  // fill moves by at most one per cycle
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + 1'b1) ||
    (fill_q == $past(fill_q) - 1'b1))
    else $error("fill count jumped");

endmodule

`default_nettype wire
